FILE: src/dpct_pkg.sv
package dpct_pkg;

  // Default table geometry
  localparam int unsigned TABLE_ENTRIES_DEF = 65536;
  localparam int unsigned DEPTH_BITS_DEF    = 6;

  // Fixed field widths of the item ports
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 64;
  localparam int unsigned SDEPTH_W = 6;

  // Item actions
  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  typedef struct packed {
    logic                action;
    logic [KEY_W-1:0]    position_key;
    logic [SDEPTH_W-1:0] search_depth;
    logic [COUNT_W-1:0]  count_in;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] count_out;
    logic               written;
  } out_item_t;

endpackage

FILE: src/depth_preferred_count_table_unit.sv
// Depth-preferred count table: a direct-mapped table of TABLE_ENTRIES entries, each holding a
// 64-bit key, a DEPTH_BITS depth and a 64-bit node count, indexed by the low bits of the key.
// A probe item (action 0) returns hit and the stored count when key and depth both match, else
// hit 0 and count 0. A store item (action 1) overwrites the entry when its depth is at least the
// stored depth (ties replace) and returns written. After reset the block runs a clearing pass
// (one entry per cycle) with in_ready low; the table then reads as all zero. Each item goes
// through a synchronous read of the entry memory on acceptance, then a compare, write-back and
// load of the output register. Only one item is in flight at a time. A finished result waits in
// the output register while the next item is accepted, and resolution stalls only if that
// register is still full.
module depth_preferred_count_table_unit #(
  parameter int unsigned TABLE_ENTRIES = dpct_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned DEPTH_BITS    = dpct_pkg::DEPTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dpct_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dpct_pkg::out_item_t out_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  // Entry word layout: {key, count, depth}
  localparam int unsigned ENT_W = dpct_pkg::KEY_W + dpct_pkg::COUNT_W + DEPTH_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR   = 3'b001,
    ST_IDLE    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     clr_idx_r, clr_idx_nxt;
  dpct_pkg::in_item_t   item_r;
  logic [ENT_W-1:0]     rd_data_r;
  logic                 out_valid_r, out_valid_nxt;
  dpct_pkg::out_item_t  out_data_r, out_data_nxt;

  // Entry memory
  logic [ENT_W-1:0]     mem_q [TABLE_ENTRIES];
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;

  logic                 in_fire;
  logic                 resolve_fire;
  logic [IDX_W-1:0]     item_idx;
  logic [DEPTH_BITS-1:0] req_depth;
  logic [dpct_pkg::KEY_W-1:0]   held_key;
  logic [dpct_pkg::COUNT_W-1:0] held_count;
  logic [DEPTH_BITS-1:0] held_depth;
  logic                 key_match;
  logic                 replace;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Result can leave when the output register is empty or draining this cycle
  assign resolve_fire = (state_r == ST_RESOLVE) && (!out_valid_r || out_ready);

  assign item_idx   = item_r.position_key[IDX_W-1:0];
  assign req_depth  = DEPTH_BITS'(item_r.search_depth);
  assign held_key   = rd_data_r[ENT_W-1 -: dpct_pkg::KEY_W];
  assign held_count = rd_data_r[DEPTH_BITS +: dpct_pkg::COUNT_W];
  assign held_depth = rd_data_r[DEPTH_BITS-1:0];
  assign key_match  = (held_key == item_r.position_key) && (held_depth == req_depth);
  assign replace    = (req_depth >= held_depth);

  // Write port: clearing sweep or write-back of a replacing store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (resolve_fire && (item_r.action == dpct_pkg::ACT_STORE) && replace) begin
      mem_we    = 1'b1;
      mem_waddr = item_idx;
      mem_wdata = {item_r.position_key, item_r.count_in, req_depth};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // Read issued on the accept edge; data is ready in ST_RESOLVE
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= mem_q[in_data.position_key[IDX_W-1:0]];
      item_r    <= in_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == {IDX_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (resolve_fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (item_r.action == dpct_pkg::ACT_STORE) begin
            out_data_nxt.hit       = 1'b0;
            out_data_nxt.count_out = '0;
            out_data_nxt.written   = replace;
          end else begin
            out_data_nxt.hit       = key_match;
            out_data_nxt.count_out = key_match ? held_count : '0;
            out_data_nxt.written   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result only appears right after a resolve cycle
  a_result_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESOLVE))
    else $error("result appeared without a resolve cycle");

  // No items are taken during the clearing sweep
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during clearing sweep");

  // Item write-back only for a store
  a_write_only_store: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == ST_RESOLVE)) |-> (item_r.action == dpct_pkg::ACT_STORE))
    else $error("table written by a probe");

  // hit and written never both set
  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.hit && out_data_r.written))
    else $error("result has both hit and written");

endmodule

FILE: verif/tb_depth_preferred_count_table_unit.sv
`timescale 1ns / 1ps

module tb_depth_preferred_count_table_unit;

  // Table geometry as instantiated (block defaults)
  localparam int unsigned ENTRIES = dpct_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned SLOT_W  = $clog2(ENTRIES);

  // The block clears one entry per cycle after reset with in_ready low, so a
  // quiet spell the length of that clearing pass is normal once. The watchdog allows that
  // several times over on top of the worst stall of either side.
  localparam int unsigned QUIET_LIMIT  = 4 * ENTRIES + 2000;
  localparam int unsigned RANDOM_ITEMS = 1230;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  dpct_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dpct_pkg::out_item_t out_data;

  depth_preferred_count_table_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table. Cleared at reset, same as the block after its
  // clearing pass.
  // ---------------------------------------------------------------------------
  logic [dpct_pkg::KEY_W-1:0]    shadow_keys   [ENTRIES];
  logic [dpct_pkg::COUNT_W-1:0]  shadow_counts [ENTRIES];
  logic [dpct_pkg::SDEPTH_W-1:0] shadow_depths [ENTRIES];

  dpct_pkg::out_item_t pending_lookups[$];   // expected results, oldest first

  int unsigned mismatches = 0;
  int unsigned n_probes = 0, n_hits = 0, n_stores = 0, n_writes = 0;
  int unsigned n_results = 0;
  bit          no_idle = 1'b0;     // both sides run flat out while set

  // Probe: hit only when key and depth both match the entry.
  // Store: replace when the new depth is at least the held one (ties win).
  function automatic dpct_pkg::out_item_t resolve_lookup(input dpct_pkg::in_item_t it);
    dpct_pkg::out_item_t r;
    logic [SLOT_W-1:0]   slot;
    slot = it.position_key[SLOT_W-1:0];
    r = '0;
    if (it.action == dpct_pkg::ACT_PROBE) begin
      r.hit = (shadow_keys[slot] == it.position_key) &&
              (shadow_depths[slot] == it.search_depth);
      r.count_out = r.hit ? shadow_counts[slot] : '0;
    end else begin
      r.written = (it.search_depth >= shadow_depths[slot]);
      if (r.written) begin
        shadow_keys[slot]   = it.position_key;
        shadow_counts[slot] = it.count_in;
        shadow_depths[slot] = it.search_depth;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one item per call. Unless no_idle is set, random idle cycles go in front of the item;
  // valid then stays high with the payload held until in_ready is seen at an
  // edge. Returns right at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input dpct_pkg::in_item_t it, input bit typed,
                           input dpct_pkg::out_item_t typed_want);
    dpct_pkg::out_item_t want;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 15) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge; the shadow table moves in acceptance order
    want = resolve_lookup(it);
    if (typed) want = typed_want;
    if (it.action == dpct_pkg::ACT_PROBE) begin
      n_probes++;
      if (want.hit) n_hits++;
    end else begin
      n_stores++;
      if (want.written) n_writes++;
    end
    pending_lookups.push_back(want);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: walked in order. Where the answer is plain from the rules
  // it is typed in; the rest go through the shadow table.
  // ---------------------------------------------------------------------------
  typedef struct {
    dpct_pkg::in_item_t  stim;
    bit                  typed;
    dpct_pkg::out_item_t want;
  } lookup_row_t;

  lookup_row_t directed_rows[$];

  task automatic add_row(input logic act, input logic [63:0] key, input logic [5:0] dep,
                         input logic [63:0] cnt, input bit typed, input logic hit,
                         input logic [63:0] cnt_out, input logic wr);
    lookup_row_t r;
    r.stim.action       = act;
    r.stim.position_key = key;
    r.stim.search_depth = dep;
    r.stim.count_in     = cnt;
    r.typed             = typed;
    r.want.hit          = hit;
    r.want.count_out    = cnt_out;
    r.want.written      = wr;
    directed_rows.push_back(r);
  endtask

  localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_A = 64'h5555_5555_5555_0000;  // slot 0, alias of key 0
  localparam logic [63:0] KEY_B = 64'hAAAA_AAAA_AAAA_0000;  // slot 0 as well
  localparam logic [63:0] KEY_C = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] PAT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] PAT_5 = 64'h5555_5555_5555_5555;

  task automatic build_directed_rows();
    // cleared entry: key 0 depth 0 hits with count 0
    add_row(dpct_pkg::ACT_PROBE, 64'd0, 6'd0,  ONES,  1'b1, 1'b1, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_PROBE, 64'd0, 6'd63, 64'd0, 1'b1, 1'b0, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_PROBE, ONES,  6'd0,  64'd0, 1'b1, 1'b0, 64'd0, 1'b0);
    // extremes, deeper store wins, shallower one is refused
    add_row(dpct_pkg::ACT_STORE, ONES,  6'd63, ONES,  1'b1, 1'b0, 64'd0, 1'b1);
    add_row(dpct_pkg::ACT_PROBE, ONES,  6'd63, 64'd0, 1'b1, 1'b1, ONES,  1'b0);
    add_row(dpct_pkg::ACT_STORE, ONES,  6'd62, 64'd0, 1'b1, 1'b0, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_PROBE, ONES,  6'd62, ONES,  1'b1, 1'b0, 64'd0, 1'b0);
    // equal depth replaces
    add_row(dpct_pkg::ACT_STORE, ONES,  6'd63, 64'd0, 1'b1, 1'b0, 64'd0, 1'b1);
    add_row(dpct_pkg::ACT_PROBE, ONES,  6'd63, ONES,  1'b1, 1'b1, 64'd0, 1'b0);
    // aliasing keys in one slot
    add_row(dpct_pkg::ACT_STORE, KEY_A, 6'd0,  PAT_A, 1'b1, 1'b0, 64'd0, 1'b1);
    add_row(dpct_pkg::ACT_PROBE, 64'd0, 6'd0,  64'd0, 1'b1, 1'b0, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_PROBE, KEY_A, 6'd0,  PAT_5, 1'b1, 1'b1, PAT_A, 1'b0);
    add_row(dpct_pkg::ACT_STORE, KEY_B, 6'd1,  PAT_5, 1'b1, 1'b0, 64'd0, 1'b1);
    add_row(dpct_pkg::ACT_PROBE, KEY_A, 6'd0,  64'd0, 1'b1, 1'b0, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_PROBE, KEY_B, 6'd1,  64'd0, 1'b1, 1'b1, PAT_5, 1'b0);
    // key matches, depth does not
    add_row(dpct_pkg::ACT_PROBE, KEY_B, 6'd2,  64'd0, 1'b1, 1'b0, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_STORE, KEY_B, 6'd0,  64'd1, 1'b1, 1'b0, 64'd0, 1'b0);
    // back-to-back read after write on one entry
    add_row(dpct_pkg::ACT_STORE, KEY_C, 6'd42, 64'h8000_0000_0000_0001,
            1'b0, 1'b0, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_PROBE, KEY_C, 6'd42, 64'd0, 1'b0, 1'b0, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_STORE, KEY_C, 6'd42, 64'd1, 1'b0, 1'b0, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_PROBE, KEY_C, 6'd42, 64'd0, 1'b0, 1'b0, 64'd0, 1'b0);
    add_row(dpct_pkg::ACT_STORE, 64'd0, 6'd0,  64'd0, 1'b1, 1'b0, 64'd0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic. Keys come mostly from a small pool crowded onto a few
  // slots, so probes hit, stores collide and depth preference matters.
  // Depths stay low mostly so slots do not lock at a deep entry early.
  // ---------------------------------------------------------------------------
  logic [63:0] key_pool[32];

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [5:0] pool_depth();
    return ($urandom_range(0, 99) < 95) ? 6'($urandom_range(0, 9)) : 6'($urandom_range(0, 63));
  endfunction

  task automatic run_random_traffic();
    dpct_pkg::in_item_t  it;
    dpct_pkg::out_item_t none;
    int unsigned n;
    int unsigned pick;
    bit          paused;
    none   = '0;
    n      = 0;
    paused = 1'b0;
    foreach (key_pool[i]) begin
      key_pool[i] = rand_word();
      if (i < 24) key_pool[i][15:0] = 16'($urandom_range(0, 7));
    end
    while (n < RANDOM_ITEMS) begin
      no_idle = (n >= 400 && n < 700);
      if (!paused && n >= 800) begin
        // let the pipe empty completely once mid-run
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // store then probe of the same key and depth
        it.action       = dpct_pkg::ACT_STORE;
        it.position_key = key_pool[$urandom_range(0, 31)];
        it.search_depth = pool_depth();
        it.count_in     = rand_word();
        send_item(it, 1'b0, none);
        it.action   = dpct_pkg::ACT_PROBE;
        it.count_in = rand_word();
        send_item(it, 1'b0, none);
        n += 2;
      end else if (pick < 85) begin
        it.action       = dpct_pkg::ACT_PROBE;
        it.position_key = key_pool[$urandom_range(0, 31)];
        it.search_depth = pool_depth();
        it.count_in     = rand_word();
        send_item(it, 1'b0, none);
        n++;
      end else begin
        // noise: any key, any depth, either action
        it.action       = ($urandom_range(0, 1) == 0) ? dpct_pkg::ACT_PROBE
                                                      : dpct_pkg::ACT_STORE;
        it.position_key = rand_word();
        it.search_depth = (it.action == dpct_pkg::ACT_STORE && $urandom_range(0, 4) != 0) ?
                          pool_depth() : 6'($urandom_range(0, 63));
        it.count_in     = rand_word();
        send_item(it, 1'b0, none);
        n++;
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: compare every accepted result with the oldest expectation,
  // then pick the next ready at random, or hold it high while no_idle is set.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dpct_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_lookups.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data), 64'd0);
        end else begin
          want = pending_lookups.pop_front();
          if (out_data.hit !== want.hit)
            report_mismatch("hit", 64'(out_data.hit), 64'(want.hit));
          if (out_data.count_out !== want.count_out)
            report_mismatch("count_out", out_data.count_out, want.count_out);
          if (out_data.written !== want.written)
            report_mismatch("written", 64'(out_data.written), 64'(want.written));
        end
      end
      out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 15);
    end
  end

  // Watchdog: cycles in a row with no item moving on either side.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("depth_preferred_count_table_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_keys[i]   = '0;
      shadow_counts[i] = '0;
      shadow_depths[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    build_directed_rows();
    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    run_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_lookups.size() != 0)
      report_mismatch("results never returned", 64'(pending_lookups.size()), 64'd0);

    $display("covered %0d probes (%0d hits) and %0d stores (%0d replaced), %0d results",
             n_probes, n_hits, n_stores, n_writes, n_results);
    $display("aliased keys, depth ties and refusals, idle and back-pressure on both sides");
    if (mismatches == 0) begin
      $display("depth_preferred_count_table_unit test passed");
    end else begin
      $display("depth_preferred_count_table_unit test failed");
    end
    $finish;
  end

endmodule
